// File: rtl/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared types and constants of the three-voice wavetable synthesizer:
// command codes, nibble register map, field widths and sequencer states.
// ----------------------------------------------------------------------------
package wts_pkg;

  // Field widths
  localparam int OPCODE_W  = 2;
  localparam int ADDR_W    = 9;
  localparam int DATA_W    = 8;
  localparam int SAMPLE_W  = 16;
  localparam int IN_DATA_W = 24;  // address and data, padded to whole bytes
  localparam int PHASE1_W  = 20;
  localparam int PHASE_W   = 16;
  localparam int NIB_W     = 4;
  localparam int ROM_AW    = 9;
  localparam int ROM_DEPTH = 512;
  localparam int REG_AW    = 5;

  // Command codes carried in tuser
  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ROM_LOAD = 2'd2;

  // Nibble register map
  localparam logic [REG_AW-1:0] REG_V1_PHASE = 5'd0;
  localparam logic [REG_AW-1:0] REG_WAVE0    = 5'd5;
  localparam logic [REG_AW-1:0] REG_V2_PHASE = 5'd6;
  localparam logic [REG_AW-1:0] REG_WAVE1    = 5'd10;
  localparam logic [REG_AW-1:0] REG_V3_PHASE = 5'd11;
  localparam logic [REG_AW-1:0] REG_WAVE2    = 5'd15;
  localparam logic [REG_AW-1:0] REG_V1_STEP  = 5'd16;
  localparam logic [REG_AW-1:0] REG_VOL0     = 5'd21;
  localparam logic [REG_AW-1:0] REG_V2_STEP  = 5'd22;
  localparam logic [REG_AW-1:0] REG_VOL1     = 5'd26;
  localparam logic [REG_AW-1:0] REG_V3_STEP  = 5'd27;
  localparam logic [REG_AW-1:0] REG_VOL2     = 5'd31;

  // Voice indexes
  localparam logic [1:0] VOICE1 = 2'd0;
  localparam logic [1:0] VOICE2 = 2'd1;
  localparam logic [1:0] VOICE3 = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  // Replace one nibble of a 20-bit word; positions above four leave it as is
  function automatic logic [PHASE1_W-1:0] set_nibble(
    input logic [PHASE1_W-1:0] word,
    input logic [2:0]          pos,
    input logic [NIB_W-1:0]    nib
  );
    logic [PHASE1_W-1:0] res;
    res = word;
    for (int i = 0; i < PHASE1_W / NIB_W; i++) begin
      if (pos == 3'(i)) begin
        res[i*NIB_W +: NIB_W] = nib;
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/wavetable_three_voice_synth.sv
// ----------------------------------------------------------------------------
// wavetable_three_voice_synth
// Three-voice wavetable sound generator. Each transfer on the input stream
// carries a command in tuser: a nibble register write, a wave ROM load, or a
// sample tick. Writes and loads finish in the cycle they are taken and give
// no output. A tick advances all three phase accumulators and mixes one
// signed 16-bit sample onto the output stream. The voices are worked one
// after another through a single 20-bit adder, the wave ROM read port and a
// small level multiplier, each voice passing the add, read, multiply and
// accumulate states. A tick keeps the input stalled until its sample enters
// the output register, longer while the previous sample still waits there.
// The 512x4 wave ROM has no reset and must be loaded before the first tick.
// ----------------------------------------------------------------------------
module wavetable_three_voice_synth (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [8:0] address, [16:9] data, [23:17] zero
  input  logic [wts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [wts_pkg::OPCODE_W-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] sample
  output logic [wts_pkg::SAMPLE_W-1:0]   m_axis_tdata
);
  import wts_pkg::*;

  state_t state, state_next;

  logic                  in_xfer;
  logic [ADDR_W-1:0]     in_addr;
  logic [NIB_W-1:0]      in_nib;
  logic [REG_AW-1:0]     reg_a;
  logic                  reg_we;

  // Voice registers
  logic [PHASE1_W-1:0]   phase1, step1;
  logic [PHASE_W-1:0]    phase2, phase3, step2, step3;
  logic [NIB_W-1:0]      volume [3];
  logic [NIB_W-1:0]      wave   [3];

  // Sequencer datapath
  logic [1:0]            vidx;
  logic [ROM_AW-1:0]     rom_addr;
  logic [NIB_W-1:0]      rom_q;
  logic [NIB_W-1:0]      rom [ROM_DEPTH];
  logic signed [15:0]    term;
  logic signed [15:0]    acc;

  logic [PHASE1_W-1:0]   cur_phase, cur_step;
  logic [PHASE1_W-1:0]   add_a, add_b, add_sum;
  logic signed [4:0]     nib_s;
  logic signed [9:0]     level;
  logic signed [15:0]    level_w, term_next;
  logic                  out_load;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_addr = s_axis_tdata[ADDR_W-1:0];
  assign in_nib  = s_axis_tdata[ADDR_W +: NIB_W];
  assign reg_a   = in_addr[REG_AW-1:0];
  assign reg_we  = in_xfer && (s_axis_tuser == OP_WRITE) &&
                   (in_addr[ADDR_W-1:REG_AW] == '0);

  // Select the current voice's phase and step
  always_comb begin
    case (vidx)
      VOICE1: begin
        cur_phase = phase1;
        cur_step  = step1;
      end
      VOICE2: begin
        cur_phase = {4'b0, phase2};
        cur_step  = {4'b0, step2};
      end
      default: begin
        cur_phase = {4'b0, phase3};
        cur_step  = {4'b0, step3};
      end
    endcase
  end

  // Shared adder: phase advance, then sample accumulation
  always_comb begin
    case (state)
      ST_ADD: begin
        add_a = cur_phase;
        add_b = cur_step;
      end
      ST_ACC: begin
        add_a = {{4{acc[15]}}, acc};
        add_b = {{4{term[15]}}, term};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
    add_sum = add_a + add_b;
  end

  // Voice level: (nibble - 8) * volume * 68
  always_comb begin
    nib_s     = $signed({1'b0, rom_q}) - 5'sd8;
    level     = nib_s * $signed({1'b0, volume[vidx]});
    level_w   = {{6{level[9]}}, level};
    term_next = (level_w <<< 6) + (level_w <<< 2);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (s_axis_tuser == OP_TICK)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD:  state_next = ST_READ;
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        state_next = (vidx == VOICE3) ? ST_DONE : ST_ADD;
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Voice registers: nibble writes and phase advance
  always_ff @(posedge clk) begin
    if (rst) begin
      phase1 <= '0;
      phase2 <= '0;
      phase3 <= '0;
      step1  <= '0;
      step2  <= '0;
      step3  <= '0;
      for (int i = 0; i < 3; i++) begin
        volume[i] <= '0;
        wave[i]   <= '0;
      end
    end else if (reg_we) begin
      if (reg_a < REG_WAVE0) begin
        phase1 <= set_nibble(phase1, 3'(reg_a - REG_V1_PHASE), in_nib);
      end else if (reg_a == REG_WAVE0) begin
        wave[0] <= in_nib;
      end else if (reg_a < REG_WAVE1) begin
        phase2 <= PHASE_W'(set_nibble({4'b0, phase2}, 3'(reg_a - REG_V2_PHASE), in_nib));
      end else if (reg_a == REG_WAVE1) begin
        wave[1] <= in_nib;
      end else if (reg_a < REG_WAVE2) begin
        phase3 <= PHASE_W'(set_nibble({4'b0, phase3}, 3'(reg_a - REG_V3_PHASE), in_nib));
      end else if (reg_a == REG_WAVE2) begin
        wave[2] <= in_nib;
      end else if (reg_a < REG_VOL0) begin
        step1 <= set_nibble(step1, 3'(reg_a - REG_V1_STEP), in_nib);
      end else if (reg_a == REG_VOL0) begin
        volume[0] <= in_nib;
      end else if (reg_a < REG_VOL1) begin
        step2 <= PHASE_W'(set_nibble({4'b0, step2}, 3'(reg_a - REG_V2_STEP), in_nib));
      end else if (reg_a == REG_VOL1) begin
        volume[1] <= in_nib;
      end else if (reg_a < REG_VOL2) begin
        step3 <= PHASE_W'(set_nibble({4'b0, step3}, 3'(reg_a - REG_V3_STEP), in_nib));
      end else begin
        volume[2] <= in_nib;
      end
    end else if (state == ST_ADD) begin
      case (vidx)
        VOICE1:  phase1 <= add_sum;
        VOICE2:  phase2 <= add_sum[PHASE_W-1:0];
        default: phase3 <= add_sum[PHASE_W-1:0];
      endcase
    end
  end

  // Wave ROM: load port and registered read
  always_ff @(posedge clk) begin
    if (in_xfer && (s_axis_tuser == OP_ROM_LOAD)) begin
      rom[in_addr] <= in_nib;
    end
    if (state == ST_READ) begin
      rom_q <= rom[rom_addr];
    end
  end

  // Sequencer datapath: voice index, ROM address, level and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      vidx <= VOICE1;
    end else begin
      case (state)
        ST_IDLE: begin
          vidx <= VOICE1;
          acc  <= '0;
        end
        ST_ADD: begin
          rom_addr <= (vidx == VOICE1) ? {wave[vidx], add_sum[19:15]}
                                       : {wave[vidx], add_sum[15:11]};
        end
        ST_MUL: term <= term_next;
        ST_ACC: begin
          acc <= add_sum[15:0];
          if (vidx != VOICE3) begin
            vidx <= vidx + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= acc;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // A tick starts the sequence at voice one
  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (s_axis_tuser == OP_TICK)) |=> (state == ST_ADD && vidx == VOICE1))
    else $error("tick did not start the voice sequence");

  // Writes, loads and the unused opcode complete at once
  a_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (s_axis_tuser != OP_TICK)) |=> (state == ST_IDLE))
    else $error("register or ROM command left the idle state");

  // A sample appears only after the last voice
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_DONE))
    else $error("sample presented outside the done state");

  // Voice index stays within three voices
  a_vidx: assert property (@(posedge clk) disable iff (rst)
    (vidx == VOICE1 || vidx == VOICE2 || vidx == VOICE3))
    else $error("voice index out of range");

  // Third voice's accumulation ends the sequence
  a_last_voice: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && vidx == VOICE3) |=> (state == ST_DONE))
    else $error("sequence did not end after the third voice");
`endif

endmodule

// File: test/wts_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wts_sample_checker
// Watches both streams of the wavetable synthesizer. Every write and ROM load taken on
// the input stream updates a private copy of the voice registers and wave ROM;
// every tick adds the predicted mixed sample to a queue, and each output
// transfer is compared with the oldest queued sample.
// ----------------------------------------------------------------------------
module wts_sample_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [wts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [wts_pkg::OPCODE_W-1:0]   s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [wts_pkg::SAMPLE_W-1:0]   m_axis_tdata,
  output int                             pending,
  output int                             errors
);
  import wts_pkg::*;

  // Shadow copy of the voice state
  logic [PHASE1_W-1:0] v1_phase, v1_step;
  logic [PHASE_W-1:0]  v2_phase, v2_step, v3_phase, v3_step;
  logic [NIB_W-1:0]    level [3];
  logic [NIB_W-1:0]    wave_sel [3];
  logic [NIB_W-1:0]    wave_mem [ROM_DEPTH];

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int err_count = 0;

  initial begin
    pending = 0;
    errors  = 0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      wave_mem[i] = '0;
    end
  end

  // Signed contribution of one voice: centered wave nibble times level times 68
  function automatic int voice_level(input logic [4:0] top5, input logic [NIB_W-1:0] wv,
                                     input logic [NIB_W-1:0] vol);
    logic [ROM_AW-1:0] idx;
    idx = {wv, top5};
    return (int'(wave_mem[idx]) - 8) * int'(vol) * 68;
  endfunction

  // Update one nibble register
  task automatic write_nibble_reg(input logic [REG_AW-1:0] a, input logic [NIB_W-1:0] nib);
    int pos;
    if (a < REG_WAVE0) begin
      pos = int'(a - REG_V1_PHASE);
      v1_phase[pos*NIB_W +: NIB_W] = nib;
    end else if (a == REG_WAVE0) begin
      wave_sel[VOICE1] = nib;
    end else if (a < REG_WAVE1) begin
      pos = int'(a - REG_V2_PHASE);
      v2_phase[pos*NIB_W +: NIB_W] = nib;
    end else if (a == REG_WAVE1) begin
      wave_sel[VOICE2] = nib;
    end else if (a < REG_WAVE2) begin
      pos = int'(a - REG_V3_PHASE);
      v3_phase[pos*NIB_W +: NIB_W] = nib;
    end else if (a == REG_WAVE2) begin
      wave_sel[VOICE3] = nib;
    end else if (a < REG_VOL0) begin
      pos = int'(a - REG_V1_STEP);
      v1_step[pos*NIB_W +: NIB_W] = nib;
    end else if (a == REG_VOL0) begin
      level[VOICE1] = nib;
    end else if (a < REG_VOL1) begin
      pos = int'(a - REG_V2_STEP);
      v2_step[pos*NIB_W +: NIB_W] = nib;
    end else if (a == REG_VOL1) begin
      level[VOICE2] = nib;
    end else if (a < REG_VOL2) begin
      pos = int'(a - REG_V3_STEP);
      v3_step[pos*NIB_W +: NIB_W] = nib;
    end else begin
      level[VOICE3] = nib;
    end
  endtask

  // Advance all accumulators and queue the mixed sample
  task automatic advance_and_mix();
    int sum;
    v1_phase = v1_phase + v1_step;
    v2_phase = v2_phase + v2_step;
    v3_phase = v3_phase + v3_step;
    sum = voice_level(v1_phase[PHASE1_W-1 -: 5], wave_sel[VOICE1], level[VOICE1])
        + voice_level(v2_phase[PHASE_W-1 -: 5],  wave_sel[VOICE2], level[VOICE2])
        + voice_level(v3_phase[PHASE_W-1 -: 5],  wave_sel[VOICE3], level[VOICE3]);
    expected_samples.push_back(sum[SAMPLE_W-1:0]);
  endtask

  // Compare results first, then absorb the command taken at this edge
  always @(posedge clk) begin : observe
    logic signed [SAMPLE_W-1:0] want;
    logic [ADDR_W-1:0]          addr;
    logic [NIB_W-1:0]           nib;
    if (rst) begin
      v1_phase = '0;
      v1_step  = '0;
      v2_phase = '0;
      v2_step  = '0;
      v3_phase = '0;
      v3_step  = '0;
      for (int v = 0; v < 3; v++) begin
        level[v]    = '0;
        wave_sel[v] = '0;
      end
      expected_samples.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $error("sample: unexpected transfer, actual %0d", $signed(m_axis_tdata));
          err_count++;
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata !== want) begin
            $error("sample: expected %0d, actual %0d", want, $signed(m_axis_tdata));
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        addr = s_axis_tdata[ADDR_W-1:0];
        nib  = s_axis_tdata[ADDR_W +: NIB_W];
        case (s_axis_tuser)
          OP_TICK:     advance_and_mix();
          OP_WRITE:    if (addr < 32) write_nibble_reg(addr[REG_AW-1:0], nib);
          OP_ROM_LOAD: wave_mem[addr] = nib;
          default:     ;
        endcase
      end
    end
    pending <= expected_samples.size();
    errors  <= err_count;
  end

endmodule

// File: test/tb_wavetable_three_voice_synth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wavetable_three_voice_synth
// Drives register writes, wave ROM loads and sample ticks into the
// synthesizer with bursty input and a stalling output side. A directed part
// hits the sample extremes, phase and step wrap, ignored commands and masked
// data bits; a random part mixes full wave loads, voice setups, tick bursts
// and noise. The checker module predicts and compares; this module decides
// the verdict.
// ----------------------------------------------------------------------------
module tb_wavetable_three_voice_synth;
  import wts_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  localparam int TARGET_COMMANDS = 950;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 400000;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [OPCODE_W-1:0]  s_axis_tuser = OP_TICK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]  m_axis_tdata;

  int pending;
  int errors;
  int cycle_count = 0;
  int burst_left = 0;
  int accepted_commands = 0;
  bit wave_loaded [16];

  wavetable_three_voice_synth u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wts_sample_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .errors        (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wavetable_three_voice_synth verification failed");
      $finish;
    end
  end

  // Output side: stretches of random stall patterns, one long hold-off
  initial begin : result_sink
    int mode;
    @(negedge rst);
    for (int stretch = 0; ; stretch++) begin
      if (stretch == 4) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(50, 300)) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 9) < 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one command and hold it until transferred; idle between bursts
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W-ADDR_W-DATA_W){1'b0}}, val, addr};
    do @(posedge clk); while (!s_axis_tready);
    if (op != OP_RESERVED && !(op == OP_WRITE && addr >= 32)) begin
      accepted_commands++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  // Stop offering and wait until every queued sample has come out
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Fill all 32 entries of one waveform with random nibbles
  task automatic load_wave(input logic [3:0] w);
    for (int i = 0; i < 32; i++) begin
      send_item(OP_ROM_LOAD, {w, 5'(i)}, 8'($urandom_range(0, 255)));
    end
    wave_loaded[w] = 1'b1;
  endtask

  function automatic logic [3:0] pick_loaded_wave();
    logic [3:0] w;
    do w = 4'($urandom_range(0, 15)); while (!wave_loaded[w]);
    return w;
  endfunction

  // Random register write; wave selects only point at loaded waveforms
  task automatic random_reg_write();
    logic [REG_AW-1:0] a;
    logic [DATA_W-1:0] val;
    a   = REG_AW'($urandom_range(0, 31));
    val = DATA_W'($urandom_range(0, 255));
    if (a == REG_WAVE0 || a == REG_WAVE1 || a == REG_WAVE2) begin
      val[3:0] = pick_loaded_wave();
    end
    send_item(OP_WRITE, ADDR_W'(a), val);
  endtask

  // Setup of one voice's step, wave select and volume, followed by a few ticks
  task automatic voice_setup();
    logic [REG_AW-1:0] step_reg, wave_reg, vol_reg;
    logic [DATA_W-1:0] val;
    int nibs;
    case ($urandom_range(0, 2))
      0: begin
        step_reg = REG_V1_STEP; wave_reg = REG_WAVE0; vol_reg = REG_VOL0; nibs = 5;
      end
      1: begin
        step_reg = REG_V2_STEP; wave_reg = REG_WAVE1; vol_reg = REG_VOL1; nibs = 4;
      end
      default: begin
        step_reg = REG_V3_STEP; wave_reg = REG_WAVE2; vol_reg = REG_VOL2; nibs = 4;
      end
    endcase
    for (int i = 0; i < nibs; i++) begin
      send_item(OP_WRITE, ADDR_W'(step_reg + i), DATA_W'($urandom_range(0, 255)));
    end
    val = DATA_W'($urandom_range(0, 255));
    val[3:0] = pick_loaded_wave();
    send_item(OP_WRITE, ADDR_W'(wave_reg), val);
    send_item(OP_WRITE, ADDR_W'(vol_reg), DATA_W'($urandom_range(0, 255)));
    repeat ($urandom_range(2, 6)) begin
      send_item(OP_TICK, ADDR_W'($urandom_range(0, 511)), DATA_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int sel;
    bit mid_drained;
    mid_drained = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Wave 0: low half reads zero, upper half reads fifteen; upper data bits random
    for (int i = 0; i < 32; i++) begin
      send_item(OP_ROM_LOAD, ADDR_W'(i),
                {4'($urandom_range(0, 15)), (i < 16) ? 4'h0 : 4'hF});
    end
    wave_loaded[0] = 1'b1;

    // Full level, all voices at nibble zero: most negative sample
    send_item(OP_WRITE, ADDR_W'(REG_VOL0), 8'hFF);
    send_item(OP_WRITE, ADDR_W'(REG_VOL1), 8'hFF);
    send_item(OP_WRITE, ADDR_W'(REG_VOL2), 8'hFF);
    send_item(OP_TICK, '0, '0);
    // Move every phase into the upper half: most positive sample
    send_item(OP_WRITE, ADDR_W'(REG_V1_PHASE + 4), 8'h08);
    send_item(OP_WRITE, ADDR_W'(REG_V2_PHASE + 3), 8'h08);
    send_item(OP_WRITE, ADDR_W'(REG_V3_PHASE + 3), 8'h08);
    send_item(OP_TICK, 9'h1FF, 8'hFF);
    // Ignored commands: unused opcode, register numbers out of range
    send_item(OP_RESERVED, 9'h1FF, 8'hFF);
    send_item(OP_WRITE, 9'd32, 8'h0F);
    send_item(OP_WRITE, 9'h1FF, 8'hF0);
    // Large steps so the accumulators wrap
    send_item(OP_WRITE, ADDR_W'(REG_V1_STEP + 4), 8'h0F);
    send_item(OP_WRITE, ADDR_W'(REG_V2_STEP + 3), 8'h0F);
    send_item(OP_WRITE, ADDR_W'(REG_V3_STEP + 3), 8'h0F);
    send_item(OP_TICK, '0, '0);
    send_item(OP_TICK, '0, '0);
    // Wave select with upper data bits set, one voice muted
    send_item(OP_WRITE, ADDR_W'(REG_WAVE0), 8'hF0);
    send_item(OP_WRITE, ADDR_W'(REG_VOL1), 8'h00);
    send_item(OP_TICK, '0, '0);

    accepted_commands = 0;
    while (accepted_commands < TARGET_COMMANDS) begin
      if (!mid_drained && accepted_commands >= TARGET_COMMANDS / 2) begin
        wait_for_drain();
        mid_drained = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        repeat ($urandom_range(1, 12)) begin
          send_item(OP_TICK, ADDR_W'($urandom_range(0, 511)), DATA_W'($urandom_range(0, 255)));
        end
      end else if (sel < 62) begin
        repeat ($urandom_range(1, 6)) random_reg_write();
      end else if (sel < 68) begin
        load_wave(4'($urandom_range(0, 15)));
      end else if (sel < 76) begin
        send_item(OP_ROM_LOAD, ADDR_W'($urandom_range(0, 511)), DATA_W'($urandom_range(0, 255)));
      end else if (sel < 92) begin
        voice_setup();
      end else if (sel < 96) begin
        send_item(OP_RESERVED, ADDR_W'($urandom_range(0, 511)), DATA_W'($urandom_range(0, 255)));
      end else begin
        send_item(OP_WRITE, ADDR_W'($urandom_range(32, 511)), DATA_W'($urandom_range(0, 255)));
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("wavetable_three_voice_synth verification clean");
    end else begin
      $display("wavetable_three_voice_synth verification failed");
    end
    $finish;
  end

endmodule
